>>> src/ffpa_pkg.sv
// ffpa_pkg: shared types and constants of the first-fit page allocator
// no dependencies
package ffpa_pkg;
	localparam int PAGE_COUNT = 1024;
	localparam int PAGE_AW = 10;
	localparam int CNT_W = 11;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_RESERVED = 2'd0;
	localparam kind_t KIND_FREE = 2'd1;
	localparam kind_t KIND_USED = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic [CNT_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic en;
		logic we;
		logic [PAGE_AW-1:0] addr;
		entry_t wdata;
	} ram_req_t;
endpackage

>>> src/ffpa_page_ram.sv
// ffpa_page_ram: single-port page map memory, registered read
// depends on ffpa_pkg
module ffpa_page_ram (
	input logic clk,
	input ffpa_pkg::ram_req_t req,
	output ffpa_pkg::entry_t rdata
);
	import ffpa_pkg::*;

	entry_t mem [PAGE_COUNT];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end
endmodule

>>> src/first_fit_page_allocator_core.sv
// first_fit_page_allocator_core: sequencer over the page map memory
// depends on ffpa_pkg and ffpa_page_ram
//
// channel | signals                                   | dir
// in      | in_valid in_stall func page_count start_page | in
// out     | out_valid out_stall status first_page free_pages_left | out
// cfg     | cfg_we cfg_wdata                          | in
//
// one request at a time; an entry visit is a read step plus a check step
// allocate: a read and a check per page scanned up to the chosen run, then n writes, one more for a remainder
// free: n checks, n writes, a read and a check per page walked back to the run below
// reset and every reserved_pages write sweep all 1024 map entries, in_stall high
// results sit in an output register; the next request is taken while one waits
module first_fit_page_allocator_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [ffpa_pkg::CNT_W-1:0] page_count,
	input logic [ffpa_pkg::PAGE_AW-1:0] start_page,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [ffpa_pkg::PAGE_AW-1:0] first_page,
	output logic [ffpa_pkg::CNT_W-1:0] free_pages_left,
	input logic cfg_we,
	input logic [ffpa_pkg::PAGE_AW-1:0] cfg_wdata
);
	import ffpa_pkg::*;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_A_MARK, S_A_TAIL,
		S_F_RD, S_F_CHK, S_F_MARK, S_F_BRD, S_F_BCHK, S_F_WALK, S_F_WCHK,
		S_F_MRG, S_F_CLRS, S_F_ERQ, S_F_ECHK, S_F_ECLR, S_DONE
	} state_t;

	state_t state_q;
	logic [PAGE_AW-1:0] idx_q, s_q, head_q, resv_q, first_q;
	logic [CNT_W-1:0] cnt_q, n_q, hlen_q, klen_q, free_q;
	logic [1:0] status_q;
	ram_req_t req;
	entry_t rdata;
	logic [CNT_W-1:0] end_w, ksum_w;
	logic [CNT_W:0] frange_w;

	ffpa_page_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	assign in_stall = (state_q != S_IDLE) || cfg_we;
	assign end_w = {1'b0, head_q} + hlen_q;
	assign ksum_w = {1'b0, idx_q} + klen_q;
	assign frange_w = {2'b00, start_page} + {1'b0, page_count};

	always_comb begin
		req = '0;
		case (state_q)
			S_INIT: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = idx_q;
				req.wdata.kind = (idx_q < resv_q) ? KIND_RESERVED : KIND_FREE;
				req.wdata.len = (idx_q == resv_q) ?
					(CNT_W'(PAGE_COUNT) - {1'b0, resv_q}) : '0;
			end
			S_A_RD, S_F_RD, S_F_BRD: begin
				req.en = 1'b1;
				req.addr = idx_q;
			end
			S_A_MARK: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = idx_q;
				req.wdata.kind = KIND_USED;
			end
			S_A_TAIL: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = idx_q;
				req.wdata.kind = KIND_FREE;
				req.wdata.len = hlen_q - n_q;
			end
			S_F_MARK: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = idx_q;
				req.wdata.kind = KIND_FREE;
				req.wdata.len = (idx_q == s_q) ? n_q : '0;
			end
			S_F_WALK: begin
				if (idx_q != '0 && klen_q == '0) begin
					req.en = 1'b1;
					req.addr = idx_q - 1'b1;
				end
			end
			S_F_MRG: begin
				if (klen_q != '0 && ksum_w == {1'b0, s_q}) begin
					req.en = 1'b1;
					req.we = 1'b1;
					req.addr = idx_q;
					req.wdata.kind = KIND_FREE;
					req.wdata.len = klen_q + n_q;
				end
			end
			S_F_CLRS: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = s_q;
				req.wdata.kind = KIND_FREE;
			end
			S_F_ERQ: begin
				if (!end_w[CNT_W-1]) begin
					req.en = 1'b1;
					req.addr = end_w[PAGE_AW-1:0];
				end
			end
			S_F_ECHK: begin
				if (rdata.kind == KIND_FREE && rdata.len != '0) begin
					req.en = 1'b1;
					req.we = 1'b1;
					req.addr = head_q;
					req.wdata.kind = KIND_FREE;
					req.wdata.len = hlen_q + rdata.len;
				end
			end
			S_F_ECLR: begin
				req.en = 1'b1;
				req.we = 1'b1;
				req.addr = idx_q;
				req.wdata.kind = KIND_FREE;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			idx_q <= '0;
			resv_q <= '0;
			free_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && (cfg_we || state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				resv_q <= cfg_wdata;
				idx_q <= '0;
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == PAGE_AW'(PAGE_COUNT - 1)) begin
							free_q <= CNT_W'(PAGE_COUNT) - {1'b0, resv_q};
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_valid) begin
							n_q <= page_count;
							s_q <= start_page;
							cnt_q <= page_count;
							first_q <= '0;
							if (page_count == '0) begin
								status_q <= ST_BAD;
								state_q <= S_DONE;
							end else if (!func) begin
								if (page_count > free_q) begin
									status_q <= ST_NO_FIT;
									state_q <= S_DONE;
								end else begin
									status_q <= ST_OK;
									idx_q <= '0;
									state_q <= S_A_RD;
								end
							end else if (frange_w > (CNT_W+1)'(PAGE_COUNT)) begin
								status_q <= ST_BAD;
								state_q <= S_DONE;
							end else begin
								status_q <= ST_OK;
								idx_q <= start_page;
								state_q <= S_F_RD;
							end
						end
					end
					S_A_RD: state_q <= S_A_CHK;
					S_A_CHK: begin
						if (rdata.kind == KIND_FREE && rdata.len >= n_q) begin
							head_q <= idx_q;
							hlen_q <= rdata.len;
							state_q <= S_A_MARK;
						end else if (idx_q == PAGE_AW'(PAGE_COUNT - 1)) begin
							status_q <= ST_NO_FIT;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_A_RD;
						end
					end
					S_A_MARK: begin
						idx_q <= idx_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) begin
							first_q <= head_q;
							free_q <= free_q - n_q;
							state_q <= (hlen_q > n_q) ? S_A_TAIL : S_DONE;
						end
					end
					S_A_TAIL: state_q <= S_DONE;
					S_F_RD: state_q <= S_F_CHK;
					S_F_CHK: begin
						if (rdata.kind != KIND_USED) begin
							status_q <= ST_BAD;
							state_q <= S_DONE;
						end else if (cnt_q == CNT_W'(1)) begin
							idx_q <= s_q;
							cnt_q <= n_q;
							state_q <= S_F_MARK;
						end else begin
							idx_q <= idx_q + 1'b1;
							cnt_q <= cnt_q - 1'b1;
							state_q <= S_F_RD;
						end
					end
					S_F_MARK: begin
						if (cnt_q == CNT_W'(1)) begin
							free_q <= free_q + n_q;
							head_q <= s_q;
							hlen_q <= n_q;
							if (s_q != '0) begin
								idx_q <= s_q - 1'b1;
								state_q <= S_F_BRD;
							end else begin
								state_q <= S_F_ERQ;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
							cnt_q <= cnt_q - 1'b1;
						end
					end
					S_F_BRD: state_q <= S_F_BCHK;
					S_F_BCHK: begin
						if (rdata.kind != KIND_FREE) begin
							state_q <= S_F_ERQ;
						end else begin
							klen_q <= rdata.len;
							state_q <= S_F_WALK;
						end
					end
					S_F_WALK: begin
						if (idx_q != '0 && klen_q == '0) begin
							state_q <= S_F_WCHK;
						end else begin
							state_q <= S_F_MRG;
						end
					end
					S_F_WCHK: begin
						if (rdata.kind == KIND_FREE) begin
							idx_q <= idx_q - 1'b1;
							klen_q <= rdata.len;
							state_q <= S_F_WALK;
						end else begin
							state_q <= S_F_MRG;
						end
					end
					S_F_MRG: begin
						if (klen_q != '0 && ksum_w == {1'b0, s_q}) begin
							head_q <= idx_q;
							hlen_q <= klen_q + n_q;
							state_q <= S_F_CLRS;
						end else begin
							state_q <= S_F_ERQ;
						end
					end
					S_F_CLRS: state_q <= S_F_ERQ;
					S_F_ERQ: begin
						if (!end_w[CNT_W-1]) begin
							idx_q <= end_w[PAGE_AW-1:0];
							state_q <= S_F_ECHK;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_F_ECHK: begin
						if (rdata.kind == KIND_FREE && rdata.len != '0) begin
							state_q <= S_F_ECLR;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_F_ECLR: state_q <= S_DONE;
					S_DONE: begin
						if (!out_valid || !out_stall) begin
							out_valid <= 1'b1;
							status <= status_q;
							first_page <= first_q;
							free_pages_left <= free_q;
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for first_fit_page_allocator_core
// depends on ffpa_pkg and the allocator rtl; page map predicted inside the bench
`timescale 1ns / 100ps
module tb_top;
	import ffpa_pkg::*;

	typedef struct packed {
		logic [1:0] st;
		logic [9:0] first;
		logic [10:0] left;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [10:0] page_count = '0;
	logic [9:0] start_page = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [9:0] first_page;
	logic [10:0] free_pages_left;
	logic cfg_we = 1'b0;
	logic [9:0] cfg_wdata = '0;

	kind_t map_kind [PAGE_COUNT];
	int map_len [PAGE_COUNT];
	int pages_free;
	answer_t answers [$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	int used_starts [$];
	int used_counts [$];

	first_fit_page_allocator_core uut (.*);

	initial forever #2 clk = ~clk;

	function automatic void map_init(int r);
		if (r > PAGE_COUNT) r = PAGE_COUNT;
		for (int i = 0; i < PAGE_COUNT; i++) begin
			map_kind[i] = (i < r) ? KIND_RESERVED : KIND_FREE;
			map_len[i] = 0;
		end
		if (r < PAGE_COUNT) map_len[r] = PAGE_COUNT - r;
		pages_free = PAGE_COUNT - r;
		used_starts.delete();
		used_counts.delete();
	endfunction

	function automatic answer_t predict_request(bit f, int n, int s);
		answer_t a;
		int i, len, head, k, e;
		a = '0;
		if (n == 0) a.st = ST_BAD;
		else if (!f) begin
			if (n > pages_free) a.st = ST_NO_FIT;
			else begin
				for (i = 0; i < PAGE_COUNT; i++)
					if (map_kind[i] == KIND_FREE && map_len[i] >= n) break;
				if (i >= PAGE_COUNT) a.st = ST_NO_FIT;
				else begin
					len = map_len[i];
					for (k = i; k < i + n; k++) begin
						map_kind[k] = KIND_USED;
						map_len[k] = 0;
					end
					if (len > n) map_len[i + n] = len - n;
					pages_free -= n;
					a.first = 10'(i);
					used_starts.push_back(i);
					used_counts.push_back(n);
				end
			end
		end else begin
			a.st = ST_OK;
			if (n > PAGE_COUNT - s) a.st = ST_BAD;
			else
				for (k = s; k < s + n; k++)
					if (map_kind[k] != KIND_USED) a.st = ST_BAD;
			if (a.st == ST_OK) begin
				for (k = s; k < s + n; k++) begin
					map_kind[k] = KIND_FREE;
					map_len[k] = 0;
				end
				map_len[s] = n;
				pages_free += n;
				head = s;
				if (s > 0 && map_kind[s - 1] == KIND_FREE) begin
					k = s - 1;
					while (k > 0 && map_len[k] == 0 && map_kind[k - 1] == KIND_FREE) k--;
					if (map_len[k] != 0 && k + map_len[k] == s) begin
						map_len[k] += map_len[s];
						map_len[s] = 0;
						head = k;
					end
				end
				e = head + map_len[head];
				if (e < PAGE_COUNT && map_kind[e] == KIND_FREE && map_len[e] != 0) begin
					map_len[head] += map_len[e];
					map_len[e] = 0;
				end
			end
		end
		a.left = 11'(pages_free);
		return a;
	endfunction

	task automatic send_request(bit f, int n, int s);
		if ($urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		page_count <= 11'(n);
		start_page <= 10'(s);
		do @(posedge clk); while (in_stall);
		answers.push_back(predict_request(f, n, s));
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (answers.size() != 0) @(negedge clk);
		repeat (2200) @(negedge clk);
	endtask

	task automatic write_reserved(int r);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= 10'(r);
		@(negedge clk);
		cfg_we <= 1'b0;
		map_init(r);
	endtask

	// free a previously allocated block, sometimes only a part of it
	task automatic free_some(bit partial);
		int j, s, n;
		j = $urandom_range(0, used_starts.size() - 1);
		s = used_starts[j];
		n = used_counts[j];
		used_starts.delete(j);
		used_counts.delete(j);
		if (partial && n > 1) n = $urandom_range(1, n);
		send_request(1'b1, n, s);
	endtask

	task automatic random_traffic(int items, int max_n);
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(0, 9))
				0: send_request($urandom_range(0, 1), $urandom_range(0, 2047),
					$urandom_range(0, 1023));
				1, 2, 3, 4: send_request(1'b0, $urandom_range(1, max_n), $urandom_range(0, 1023));
				default:
					if (used_starts.size() != 0) free_some($urandom_range(0, 3) == 0);
					else send_request(1'b0, $urandom_range(1, max_n), 0);
			endcase
		end
	endtask

	task automatic test_edges;
		send_request(1'b0, 0, 0);
		send_request(1'b1, 0, 5);
		send_request(1'b0, 1024, 0);
		send_request(1'b1, 1024, 0);
		send_request(1'b0, 1025, 0);
		send_request(1'b0, 2047, 1023);
		send_request(1'b1, 1, 1023);
		send_request(1'b1, 2, 1023);
		send_request(1'b1, 1024, 0);
		send_request(1'b0, 4, 0);
		send_request(1'b0, 4, 0);
		send_request(1'b0, 4, 0);
		send_request(1'b1, 4, 4);
		send_request(1'b1, 4, 4);
		send_request(1'b1, 4, 0);
		send_request(1'b1, 8, 0);
		send_request(1'b1, 4, 8);
		send_request(1'b0, 1024, 0);
		send_request(1'b1, 3, 1021);
	endtask

	task automatic test_reserved;
		write_reserved(1023);
		send_request(1'b0, 1, 0);
		send_request(1'b0, 2, 0);
		send_request(1'b1, 1, 1023);
		send_request(1'b1, 1, 0);
		write_reserved(682);
		random_traffic(60, 40);
	endtask

	task automatic test_random;
		write_reserved(0);
		random_traffic(700, 16);
		write_reserved(341);
		random_traffic(600, 100);
	endtask

	task automatic test_backpressure;
		write_reserved(16);
		hold_off = 1'b1;
		random_traffic(20, 8);
		hold_off = 1'b0;
		random_traffic(120, 64);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		map_init(0);
		test_edges();
		test_reserved();
		test_random();
		test_backpressure();
		drain();
		if (errors == 0) $display("first_fit_page_allocator_core: match");
		else $display("first_fit_page_allocator_core: mismatch");
		$finish;
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			phase = (phase + 1) % 400;
			out_stall <= (phase < 100) ? 1'b0 : ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers.size() == 0) begin
				$display("%0t: unexpected transaction st=%0d first=%0d left=%0d",
					$time, status, first_page, free_pages_left);
				errors++;
			end else begin
				want = answers.pop_front();
				if (status !== want.st) begin
					$display("%0t: status exp %0d got %0d", $time, want.st, status);
					errors++;
				end
				if (first_page !== want.first) begin
					$display("%0t: first_page exp %0d got %0d", $time, want.first, first_page);
					errors++;
				end
				if (free_pages_left !== want.left) begin
					$display("%0t: free_pages_left exp %0d got %0d", $time, want.left,
						free_pages_left);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("first_fit_page_allocator_core: mismatch");
			$finish;
		end
	end
endmodule

>>> filelist.f
src/ffpa_pkg.sv
src/ffpa_page_ram.sv
src/first_fit_page_allocator_core.sv
sim/tb_top.sv
